FILE: sv/fra_pkg.sv
package fra_pkg;

  localparam int unsigned InW  = 15;
  localparam int unsigned ProdW = 2 * InW;
  localparam int unsigned NumW = 31;
  localparam int unsigned DenW = 30;
  localparam int unsigned ShW  = 5;
  localparam int unsigned PcW  = 3;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_INC = 2'd2,
    OP_RED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    DP_LATCH = 3'd0,
    DP_MUL   = 3'd1,
    DP_FORM  = 3'd2,
    DP_COPYQ = 3'd3,
    DP_GCD   = 3'd4,
    DP_DINIT = 3'd5,
    DP_DIV   = 3'd6,
    DP_EMIT  = 3'd7
  } dp_op_e;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NO_IN    = 3'd1,
    C_ZERO     = 3'd2,
    C_NE       = 3'd3,
    C_NOT_LAST = 3'd4,
    C_OUT_BUSY = 3'd5
  } cond_e;

  localparam logic [PcW-1:0] ST_IDLE  = 3'd0;
  localparam logic [PcW-1:0] ST_MUL   = 3'd1;
  localparam logic [PcW-1:0] ST_FORM  = 3'd2;
  localparam logic [PcW-1:0] ST_TEST  = 3'd3;
  localparam logic [PcW-1:0] ST_GCD   = 3'd4;
  localparam logic [PcW-1:0] ST_DINIT = 3'd5;
  localparam logic [PcW-1:0] ST_DIV   = 3'd6;
  localparam logic [PcW-1:0] ST_OUT   = 3'd7;

  typedef struct packed {
    dp_op_e         dp_op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic zero;
    logic ne;
    logic last;
    logic busy;
  } stat_t;

  // Control store. A step whose condition holds jumps to its target,
  // otherwise the step counter moves on (the last step wraps to idle).
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t cw;
    case (pc)
      ST_IDLE:  cw = '{DP_LATCH, C_NO_IN,    ST_IDLE};
      ST_MUL:   cw = '{DP_MUL,   C_NEVER,    ST_IDLE};
      ST_FORM:  cw = '{DP_FORM,  C_NEVER,    ST_IDLE};
      ST_TEST:  cw = '{DP_COPYQ, C_ZERO,     ST_OUT};
      ST_GCD:   cw = '{DP_GCD,   C_NE,       ST_GCD};
      ST_DINIT: cw = '{DP_DINIT, C_NEVER,    ST_IDLE};
      ST_DIV:   cw = '{DP_DIV,   C_NOT_LAST, ST_DIV};
      ST_OUT:   cw = '{DP_EMIT,  C_OUT_BUSY, ST_OUT};
      default:  cw = '{DP_LATCH, C_NO_IN,    ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

FILE: sv/fra_if.sv
interface fra_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [fra_pkg::InW-1:0]     num_a;
  logic [fra_pkg::InW-1:0]     den_a;
  logic [fra_pkg::InW-1:0]     num_b;
  logic [fra_pkg::InW-1:0]     den_b;

  modport source (output valid, op, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, op, num_a, den_a, num_b, den_b, output ready);
endinterface

interface fra_out_if;
  logic                        valid;
  logic                        ready;
  logic [fra_pkg::NumW-1:0]    res_num;
  logic [fra_pkg::DenW-1:0]    res_den;

  modport source (output valid, res_num, res_den, input ready);
  modport sink   (input valid, res_num, res_den, output ready);
endinterface

FILE: sv/fra_useq.sv
module fra_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fra_pkg::stat_t  stat_i,
  output fra_pkg::ctrl_t  ctrl_o
);

  logic [fra_pkg::PcW-1:0] pc_q, pc_d;
  fra_pkg::ctrl_t          cw;
  logic                    taken;

  assign cw     = fra_pkg::ucode(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    case (cw.cond)
      fra_pkg::C_NEVER:    taken = 1'b0;
      fra_pkg::C_NO_IN:    taken = !stat_i.in_valid;
      fra_pkg::C_ZERO:     taken = stat_i.zero;
      fra_pkg::C_NE:       taken = stat_i.ne;
      fra_pkg::C_NOT_LAST: taken = !stat_i.last;
      fra_pkg::C_OUT_BUSY: taken = stat_i.busy;
      default:             taken = 1'b0;
    endcase
    pc_d = taken ? cw.target : pc_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= fra_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: sv/fra_dpath.sv
module fra_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fra_pkg::ctrl_t  ctrl_i,
  output fra_pkg::stat_t  stat_o,
  fra_in_if.sink          req_i,
  fra_out_if.source       rsp_o
);

  localparam int unsigned NumW = fra_pkg::NumW;
  localparam int unsigned DenW = fra_pkg::DenW;
  localparam int unsigned InW  = fra_pkg::InW;
  localparam int unsigned PrW  = fra_pkg::ProdW;
  localparam int unsigned ShW  = fra_pkg::ShW;

  fra_pkg::op_e     op_q;
  logic [InW-1:0]   na_q, da_q, nb_q, db_q;
  logic [PrW-1:0]   p1_q, p2_q, p3_q;
  logic [NumW-1:0]  n_q, n_d;
  logic [DenW-1:0]  d_q, d_d;
  logic [NumW-1:0]  a_q, a_d;
  logic [DenW-1:0]  b_q, b_d;
  logic [ShW-1:0]   k_q, k_d;
  logic [ShW-1:0]   cnt_q;
  logic [NumW-1:0]  qn_q, qn_d, qd_q, qd_d;
  logic [DenW-1:0]  rn_q, rn_d, rd_q, rd_d;
  logic [NumW-1:0]  tn, td, b_ext;
  logic             gen, ged;
  logic             ovalid_q;
  logic [NumW-1:0]  onum_q;
  logic [DenW-1:0]  oden_q;
  logic             busy, accept;

  assign busy   = ovalid_q && !rsp_o.ready;
  assign accept = (ctrl_i.dp_op == fra_pkg::DP_LATCH) && req_i.valid;

  assign req_i.ready   = (ctrl_i.dp_op == fra_pkg::DP_LATCH);
  assign rsp_o.valid   = ovalid_q;
  assign rsp_o.res_num = onum_q;
  assign rsp_o.res_den = oden_q;

  assign b_ext = {1'b0, b_q};

  assign stat_o.in_valid = req_i.valid;
  assign stat_o.zero     = (n_q == '0) || (d_q == '0);
  assign stat_o.ne       = (a_q != b_ext);
  assign stat_o.last     = (cnt_q == 5'd1);
  assign stat_o.busy     = busy;

  // Form the unreduced fraction from the products (add, mul) or the inputs.
  always_comb begin
    case (op_q)
      fra_pkg::OP_ADD: begin
        n_d = NumW'(p1_q) + NumW'(p2_q);
        d_d = p3_q;
      end
      fra_pkg::OP_MUL: begin
        n_d = NumW'(p1_q);
        d_d = p3_q;
      end
      fra_pkg::OP_INC: begin
        n_d = NumW'(na_q) + NumW'(da_q);
        d_d = DenW'(da_q);
      end
      default: begin
        n_d = NumW'(na_q);
        d_d = DenW'(da_q);
      end
    endcase
  end

  // One binary GCD step. Both odd: the difference is even, so it is halved
  // at once. Common factors of two are counted in k and divided out of the
  // dividends before the division by the odd part.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (a_q != b_ext) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 5'd1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_ext) begin
        a_d = (a_q - b_ext) >> 1;
      end else begin
        b_d = DenW'((b_ext - a_q) >> 1);
      end
    end
  end

  // Restoring division, one quotient bit per lane a cycle; both lanes share
  // the divisor held in a.
  always_comb begin
    tn   = {rn_q, qn_q[NumW-1]};
    td   = {rd_q, qd_q[NumW-1]};
    gen  = (tn >= {1'b0, a_q[DenW-1:0]});
    ged  = (td >= {1'b0, a_q[DenW-1:0]});
    rn_d = gen ? DenW'(tn - {1'b0, a_q[DenW-1:0]}) : tn[DenW-1:0];
    rd_d = ged ? DenW'(td - {1'b0, a_q[DenW-1:0]}) : td[DenW-1:0];
    qn_d = {qn_q[NumW-2:0], gen};
    qd_d = {qd_q[NumW-2:0], ged};
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.dp_op)
      fra_pkg::DP_LATCH: begin
        if (accept) begin
          op_q <= fra_pkg::op_e'(req_i.op);
          na_q <= req_i.num_a;
          da_q <= req_i.den_a;
          nb_q <= req_i.num_b;
          db_q <= req_i.den_b;
        end
      end
      fra_pkg::DP_MUL: begin
        p1_q <= na_q * ((op_q == fra_pkg::OP_MUL) ? nb_q : db_q);
        p2_q <= nb_q * da_q;
        p3_q <= da_q * db_q;
      end
      fra_pkg::DP_FORM: begin
        n_q <= n_d;
        d_q <= d_d;
        a_q <= n_d;
        b_q <= d_d;
        k_q <= '0;
      end
      fra_pkg::DP_COPYQ: begin
        qn_q <= n_q;
        qd_q <= {1'b0, d_q};
      end
      fra_pkg::DP_GCD: begin
        a_q <= a_d;
        b_q <= b_d;
        k_q <= k_d;
      end
      fra_pkg::DP_DINIT: begin
        qn_q  <= n_q >> k_q;
        qd_q  <= {1'b0, d_q} >> k_q;
        rn_q  <= '0;
        rd_q  <= '0;
        cnt_q <= ShW'(NumW);
      end
      fra_pkg::DP_DIV: begin
        qn_q  <= qn_d;
        qd_q  <= qd_d;
        rn_q  <= rn_d;
        rd_q  <= rd_d;
        cnt_q <= cnt_q - 5'd1;
      end
      fra_pkg::DP_EMIT: begin
        if (!busy) begin
          onum_q <= qn_q;
          oden_q <= qd_q[DenW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctrl_i.dp_op == fra_pkg::DP_EMIT && !busy) begin
      ovalid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

endmodule

FILE: sv/fraction_arith_reduce_top.sv
// Channel  Modport             Payload
// req_i    fra_in_if.sink      op, num_a, den_a, num_b, den_b
// rsp_o    fra_out_if.source   res_num, res_den
//
// One item at a time: accept, products, form, zero test, then binary GCD
// steps (each a compare, then a halving of one or both or of their
// difference) and restoring division on two lanes in parallel. A zero
// numerator or denominator skips GCD and division. The result sits in
// an output register; the next item is taken while it waits, and the
// sequencer only stalls when a second result is ready. Reset is
// asynchronous and active low; it clears the step counter and the
// output valid flag.
module fraction_arith_reduce_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fra_in_if.sink     req_i,
  fra_out_if.source  rsp_o
);

  fra_pkg::ctrl_t ctrl;
  fra_pkg::stat_t stat;

  fra_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  fra_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: dv/fraction_arith_reduce_top_tb.sv
`timescale 1ns / 100ps

module fraction_arith_reduce_top_tb;

  localparam int ClkPeriod  = 20;
  localparam int RandItems  = 600;
  localparam int TailCycles = 120;
  localparam int WatchLimit = 3000;
  localparam int MaxReports = 20;
  localparam int NDir       = 23;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [fra_pkg::NumW-1:0] num;
    logic [fra_pkg::DenW-1:0] den;
  } frac_t;

  typedef struct packed {
    fra_pkg::op_e             op;
    logic [fra_pkg::InW-1:0]  na;
    logic [fra_pkg::InW-1:0]  da;
    logic [fra_pkg::InW-1:0]  nb;
    logic [fra_pkg::InW-1:0]  db;
    logic                     typed;
    logic [fra_pkg::NumW-1:0] rn;
    logic [fra_pkg::DenW-1:0] rd;
  } dir_row_t;

  // Rows with typed set carry a result that can be read straight off the
  // arithmetic; the others are left to the predictor.
  dir_row_t dir_tab [NDir] = '{
    '{fra_pkg::OP_RED, 15'd0, 15'd6, 15'd0, 15'd1, 1'b1, 31'd0, 30'd6},
    '{fra_pkg::OP_RED, 15'd6, 15'd0, 15'd0, 15'd1, 1'b1, 31'd6, 30'd0},
    '{fra_pkg::OP_RED, 15'd0, 15'd0, 15'd0, 15'd0, 1'b1, 31'd0, 30'd0},
    '{fra_pkg::OP_RED, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 1'b1, 31'd1, 30'd1},
    '{fra_pkg::OP_INC, 15'd0, 15'd1, 15'd32767, 15'd0, 1'b1, 31'd1, 30'd1},
    '{fra_pkg::OP_INC, 15'd32767, 15'd32767, 15'd0, 15'd0, 1'b1, 31'd2, 30'd1},
    '{fra_pkg::OP_INC, 15'd5, 15'd0, 15'd1, 15'd1, 1'b1, 31'd5, 30'd0},
    '{fra_pkg::OP_ADD, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 1'b1, 31'd2, 30'd1},
    '{fra_pkg::OP_ADD, 15'd32767, 15'd1, 15'd32767, 15'd1, 1'b1, 31'd65534, 30'd1},
    '{fra_pkg::OP_ADD, 15'd0, 15'd0, 15'd0, 15'd0, 1'b1, 31'd0, 30'd0},
    '{fra_pkg::OP_ADD, 15'd3, 15'd4, 15'd5, 15'd0, 1'b1, 31'd20, 30'd0},
    '{fra_pkg::OP_ADD, 15'd0, 15'd5, 15'd0, 15'd7, 1'b1, 31'd0, 30'd35},
    '{fra_pkg::OP_MUL, 15'd0, 15'd5, 15'd3, 15'd7, 1'b1, 31'd0, 30'd35},
    '{fra_pkg::OP_MUL, 15'd32767, 15'd1, 15'd32767, 15'd1, 1'b1, 31'd1073676289, 30'd1},
    '{fra_pkg::OP_MUL, 15'd3, 15'd4, 15'd5, 15'd0, 1'b1, 31'd15, 30'd0},
    '{fra_pkg::OP_MUL, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 1'b1, 31'd1, 30'd1},
    '{fra_pkg::OP_RED, 15'd1, 15'd1, 15'd21845, 15'd10922, 1'b1, 31'd1, 30'd1},
    '{fra_pkg::OP_ADD, 15'd1, 15'd2, 15'd1, 15'd3, 1'b0, 31'd0, 30'd0},
    '{fra_pkg::OP_MUL, 15'd2, 15'd3, 15'd3, 15'd4, 1'b0, 31'd0, 30'd0},
    '{fra_pkg::OP_INC, 15'd7, 15'd3, 15'd21845, 15'd10922, 1'b0, 31'd0, 30'd0},
    '{fra_pkg::OP_RED, 15'd12, 15'd18, 15'd10922, 15'd21845, 1'b0, 31'd0, 30'd0},
    '{fra_pkg::OP_ADD, 15'd1, 15'd32767, 15'd32766, 15'd32767, 1'b0, 31'd0, 30'd0},
    '{fra_pkg::OP_MUL, 15'd10922, 15'd21845, 15'd21845, 15'd10922, 1'b0, 31'd0, 30'd0}
  };

  logic clk_i;
  logic rst_ni;

  fra_in_if  req_if ();
  fra_out_if rsp_if ();

  fraction_arith_reduce_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  frac_t due_fractions [$];
  bit    idling_on = 1'b1;
  int    mismatches = 0;
  int    checked = 0;
  int    quiet_cycles = 0;
  int    op_count [4] = '{0, 0, 0, 0};
  int    zero_den_count = 0;
  int    stall_left = 0;

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic frac_t reduce_fraction(fra_pkg::op_e op,
                                            logic [fra_pkg::InW-1:0] na,
                                            logic [fra_pkg::InW-1:0] da,
                                            logic [fra_pkg::InW-1:0] nb,
                                            logic [fra_pkg::InW-1:0] db);
    u64_t  n;
    u64_t  d;
    u64_t  a;
    u64_t  b;
    u64_t  t;
    frac_t f;
    case (op)
      fra_pkg::OP_ADD: begin
        n = u64_t'(na) * u64_t'(db) + u64_t'(nb) * u64_t'(da);
        d = u64_t'(da) * u64_t'(db);
      end
      fra_pkg::OP_MUL: begin
        n = u64_t'(na) * u64_t'(nb);
        d = u64_t'(da) * u64_t'(db);
      end
      fra_pkg::OP_INC: begin
        n = u64_t'(na) + u64_t'(da);
        d = u64_t'(da);
      end
      default: begin
        n = u64_t'(na);
        d = u64_t'(da);
      end
    endcase
    // A fraction with a zero part is not reduced, so nothing is divided.
    if (n != 0 && d != 0) begin
      a = n;
      b = d;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      n = n / a;
      d = d / a;
    end
    f.num = n[fra_pkg::NumW-1:0];
    f.den = d[fra_pkg::DenW-1:0];
    return f;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(30, 120);
  endfunction

  // Values that are likely to share factors, plus extremes and raw noise.
  function automatic logic [fra_pkg::InW-1:0] pick_part();
    logic [fra_pkg::InW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = fra_pkg::InW'($urandom_range(1, 20));
      4, 5:    v = fra_pkg::InW'($urandom);
      6, 7:    v = fra_pkg::InW'($urandom_range(1, 63) * $urandom_range(1, 512));
      8:       v = fra_pkg::InW'(1 << $urandom_range(0, fra_pkg::InW - 1));
      default: v = fra_pkg::InW'(32767 - $urandom_range(0, 15));
    endcase
    return v;
  endfunction

  function automatic logic [fra_pkg::InW-1:0] pick_den();
    logic [fra_pkg::InW-1:0] v;
    v = pick_part();
    if (v == 0 && $urandom_range(0, 4) != 0) v = 1;
    return v;
  endfunction

  task automatic drive_item(input fra_pkg::op_e op,
                            input logic [fra_pkg::InW-1:0] na,
                            input logic [fra_pkg::InW-1:0] da,
                            input logic [fra_pkg::InW-1:0] nb,
                            input logic [fra_pkg::InW-1:0] db, input bit typed,
                            input frac_t typed_val);
    frac_t want;
    int    gap;
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.num_a <= na;
    req_if.den_a <= da;
    req_if.num_b <= nb;
    req_if.den_b <= db;
    do @(posedge clk_i); while (!req_if.ready);
    want = typed ? typed_val : reduce_fraction(op, na, da, nb, db);
    due_fractions.push_back(want);
    op_count[op]++;
    if (da == 0 || ((op == fra_pkg::OP_ADD || op == fra_pkg::OP_MUL) && db == 0))
      zero_den_count++;
    gap = (idling_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    wait (due_fractions.size() == 0);
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure, held in a counter so that each edge
  // sees exactly one update of ready.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    frac_t want;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        checked++;
        if (due_fractions.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: expected no result, got %0d/%0d", $time, rsp_if.res_num,
                     rsp_if.res_den);
        end else begin
          want = due_fractions.pop_front();
          if (rsp_if.res_num !== want.num) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: res_num expected %0d, got %0d", $time, want.num,
                       rsp_if.res_num);
          end
          if (rsp_if.res_den !== want.den) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: res_den expected %0d, got %0d", $time, want.den,
                       rsp_if.res_den);
          end
        end
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 WatchLimit, due_fractions.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    frac_t        typed_val;
    fra_pkg::op_e op;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.op    = fra_pkg::OP_ADD;
    req_if.num_a = '0;
    req_if.den_a = '0;
    req_if.num_b = '0;
    req_if.den_b = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDir; i++) begin
      typed_val.num = dir_tab[i].rn;
      typed_val.den = dir_tab[i].rd;
      drive_item(dir_tab[i].op, dir_tab[i].na, dir_tab[i].da, dir_tab[i].nb,
                 dir_tab[i].db, dir_tab[i].typed, typed_val);
    end
    drain_results();

    typed_val = '0;
    for (int i = 0; i < RandItems; i++) begin
      // A stretch with no idling on either side, then a full drain mid-run.
      idling_on = !(i >= 200 && i < 300);
      if (i == 400) drain_results();
      op = fra_pkg::op_e'($urandom_range(0, 3));
      drive_item(op, pick_part(), pick_den(), pick_part(), pick_den(), 1'b0, typed_val);
    end
    req_if.valid <= 1'b0;

    wait (due_fractions.size() == 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d items: %0d add, %0d multiply, %0d increment, %0d reduce.",
             op_count[fra_pkg::OP_ADD] + op_count[fra_pkg::OP_MUL] +
             op_count[fra_pkg::OP_INC] + op_count[fra_pkg::OP_RED],
             op_count[fra_pkg::OP_ADD], op_count[fra_pkg::OP_MUL],
             op_count[fra_pkg::OP_INC], op_count[fra_pkg::OP_RED]);
    $display("%0d had a zero denominator; %0d results checked, %0d mismatches.",
             zero_den_count, checked, mismatches);
    if (mismatches == 0 && due_fractions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
